FILE: rtl/core/keyboard_scan_code_to_ascii_defines.svh
// ---------------------------------------------------------------------------
// Keyboard scan code to ASCII - assertion macros
// Shared concurrent assertion forms for the translator modules.
// ---------------------------------------------------------------------------
`ifndef KEYBOARD_SCAN_CODE_TO_ASCII_DEFINES_SVH
`define KEYBOARD_SCAN_CODE_TO_ASCII_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KSA_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ksa same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define KSA_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ksa next-cycle check failed");

`endif

FILE: rtl/core/ksa_pkg.sv
// ---------------------------------------------------------------------------
// Keyboard scan code to ASCII - package
// Scan code constants, key tables and shared types.
// ---------------------------------------------------------------------------
package ksa_pkg;

  localparam int unsigned CODE_W   = 8;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned KEY_COUNT = 84;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_COUNT);

  // Modifier, prefix and lock codes
  localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [CODE_W-1:0] SC_EXT_PREFIX   = 8'hE0;
  localparam logic [CODE_W-1:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [CODE_W-1:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [CODE_W-1:0] SC_ALT_MAKE     = 8'h38;
  localparam logic [CODE_W-1:0] SC_ALT_BREAK    = 8'hB8;
  localparam logic [CODE_W-1:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [CODE_W-1:0] SC_NUM_MAKE     = 8'h45;
  localparam logic [CODE_W-1:0] SC_CAPS_BREAK   = 8'hBA;
  localparam logic [CODE_W-1:0] SC_NUM_BREAK    = 8'hC5;

  localparam logic [CODE_W-1:0] NUMPAD_FROM = 8'd70;
  localparam logic [CHAR_W-1:0] CTRL_MASK   = 7'h1F;

  // Table entries: bit 7 set marks a key with no character
  localparam logic [7:0] NO_CHAR = 8'h80;

  localparam logic [7:0] PLAIN_MAP [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h80, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h80, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h80, 8'h2A,
    8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h30, 8'h7F
  };

  localparam logic [7:0] UPPER_MAP [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h80, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h80, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h80, 8'h2A,
    8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h37,
    8'h38, 8'h39, 8'h80, 8'h34, 8'h35, 8'h36, 8'h80, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h7F
  };

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              alt_down;
    logic              caps_on;
    logic              num_on;
  } ksa_result_t;

endpackage

FILE: rtl/core/keyboard_scan_code_to_ascii.sv
// ---------------------------------------------------------------------------
// Keyboard scan code to ASCII - top level
// Set-1 scan code translator with shift, control, alt and lock tracking.
// ---------------------------------------------------------------------------
// Takes one raw set-1 scan code word per cycle and gives at most one ASCII
// word back. The code is held in the input register, and the translated word
// is registered in the result register, where it is valid on the result port.
// The sustained rate is one code per cycle: a code sits in the input register,
// goes through the flag update and key table lookup, and lands in the result
// register, so the only limit is the consumer's stall.
// Shift, control and alt make and break codes set and clear held flags; caps
// lock and num lock toggle on their break codes. None of these, the 0xE0
// prefix, the caps and num make codes, other break codes, codes 84 and up,
// or keys with no character give a word. Codes above 70 read the shifted
// table while num lock is on. While control is held the character keeps only
// its low five bits. Every word also reports alt, caps lock and num lock;
// caps lock is reported but not applied to letters. All flags clear on reset.
// ---------------------------------------------------------------------------
module keyboard_scan_code_to_ascii (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        scan_valid,
  output logic                        scan_stall,
  input  logic [ksa_pkg::CODE_W-1:0]  scan_code,
  output logic                        char_valid,
  input  logic                        char_stall,
  output logic [ksa_pkg::CHAR_W-1:0]  char_code,
  output logic                        alt_down,
  output logic                        caps_on,
  output logic                        num_on
);
  import ksa_pkg::*;

  logic                 out_free;
  logic                 stage_fire;
  logic [CODE_W-1:0]    stage_code;
  logic                 hit;
  ksa_result_t          result;

  // hold the incoming code word; advance it when the result side has room
  ksa_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .scan_valid  (scan_valid),
    .scan_code   (scan_code),
    .scan_stall  (scan_stall),
    .out_free    (out_free),
    .stage_code  (stage_code),
    .stage_fire  (stage_fire)
  );

  // update flags and look the key up; flags change only when the word moves on
  ksa_xlate u_xlate (
    .clk    (clk),
    .rst    (rst),
    .fire   (stage_fire),
    .code   (stage_code),
    .hit    (hit),
    .result (result)
  );

  // capture a translated word; drop codes that give no character
  ksa_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (stage_fire & hit),
    .result     (result),
    .char_stall (char_stall),
    .char_valid (char_valid),
    .char_code  (char_code),
    .alt_down   (alt_down),
    .caps_on    (caps_on),
    .num_on     (num_on),
    .out_free   (out_free)
  );

endmodule

FILE: rtl/core/ksa_in_reg.sv
// ---------------------------------------------------------------------------
// Keyboard scan code to ASCII - input register
// Holds one scan code word until the translate stage takes it.
// ---------------------------------------------------------------------------
module ksa_in_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         scan_valid,
  input  logic [ksa_pkg::CODE_W-1:0]   scan_code,
  output logic                         scan_stall,
  input  logic                         out_free,
  output logic [ksa_pkg::CODE_W-1:0]   stage_code,
  output logic                         stage_fire
);
  import ksa_pkg::*;

  logic stage_valid;
  logic take;

  // advance the held word whenever the result side has room
  assign stage_fire = stage_valid & out_free;
  assign scan_stall = stage_valid & ~out_free;
  assign take       = scan_valid & ~scan_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (stage_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_code <= scan_code;
    end
  end

endmodule

FILE: rtl/core/ksa_xlate.sv
// ---------------------------------------------------------------------------
// Keyboard scan code to ASCII - translate stage
// Modifier and lock flags plus the table lookup for one scan code.
// ---------------------------------------------------------------------------
`include "keyboard_scan_code_to_ascii_defines.svh"

module ksa_xlate (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [ksa_pkg::CODE_W-1:0]  code,
  output logic                        hit,
  output ksa_pkg::ksa_result_t        result
);
  import ksa_pkg::*;

  logic shift_held, ctrl_held, alt_held, caps_lock, num_lock;
  logic shift_held_next, ctrl_held_next, alt_held_next, caps_lock_next, num_lock_next;
  logic                 is_mod;
  logic                 in_range;
  logic                 use_upper;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [7:0]           entry;
  logic [CHAR_W-1:0]    ch;

  always_comb begin
    shift_held_next = shift_held;
    ctrl_held_next  = ctrl_held;
    alt_held_next   = alt_held;
    caps_lock_next  = caps_lock;
    num_lock_next   = num_lock;
    is_mod          = 1'b1;
    case (code)
      SC_RSHIFT_MAKE, SC_LSHIFT_MAKE:   shift_held_next = 1'b1;
      SC_RSHIFT_BREAK, SC_LSHIFT_BREAK: shift_held_next = 1'b0;
      SC_CTRL_MAKE:                     ctrl_held_next  = 1'b1;
      SC_CTRL_BREAK:                    ctrl_held_next  = 1'b0;
      SC_ALT_MAKE:                      alt_held_next   = 1'b1;
      SC_ALT_BREAK:                     alt_held_next   = 1'b0;
      SC_EXT_PREFIX, SC_CAPS_MAKE, SC_NUM_MAKE: is_mod = 1'b1;
      SC_CAPS_BREAK:                    caps_lock_next  = ~caps_lock;
      SC_NUM_BREAK:                     num_lock_next   = ~num_lock;
      default:                          is_mod          = 1'b0;
    endcase
  end

  // keypad codes follow num lock or shift, everything else follows shift only
  assign in_range  = code < CODE_W'(KEY_COUNT);
  assign key_idx   = code[KEY_IDX_W-1:0];
  assign use_upper = (code > NUMPAD_FROM) ? (num_lock | shift_held) : shift_held;
  assign entry     = use_upper ? UPPER_MAP[key_idx] : PLAIN_MAP[key_idx];
  assign ch        = ctrl_held ? (entry[CHAR_W-1:0] & CTRL_MASK) : entry[CHAR_W-1:0];
  assign hit       = ~is_mod & in_range & ~entry[7];

  assign result.char_code = ch;
  assign result.alt_down  = alt_held;
  assign result.caps_on   = caps_lock;
  assign result.num_on    = num_lock;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      ctrl_held  <= 1'b0;
      alt_held   <= 1'b0;
      caps_lock  <= 1'b0;
      num_lock   <= 1'b0;
    end else if (fire) begin
      shift_held <= shift_held_next;
      ctrl_held  <= ctrl_held_next;
      alt_held   <= alt_held_next;
      caps_lock  <= caps_lock_next;
      num_lock   <= num_lock_next;
    end
  end

  `KSA_ASSERT_NOW(a_mod_no_char, clk, rst, is_mod, !hit)
  `KSA_ASSERT_NEXT(a_num_toggle, clk, rst, fire && (code == SC_NUM_BREAK), num_lock != $past(num_lock))
  `KSA_ASSERT_NEXT(a_ctrl_set, clk, rst, fire && (code == SC_CTRL_MAKE), ctrl_held)
  `KSA_ASSERT_NOW(a_ctrl_mask, clk, rst, hit && ctrl_held, result.char_code[6:5] == 2'b00)

endmodule

FILE: rtl/core/ksa_out_reg.sv
// ---------------------------------------------------------------------------
// Keyboard scan code to ASCII - result register
// Holds a translated word until the consumer takes it.
// ---------------------------------------------------------------------------
module ksa_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  ksa_pkg::ksa_result_t          result,
  input  logic                          char_stall,
  output logic                          char_valid,
  output logic [ksa_pkg::CHAR_W-1:0]    char_code,
  output logic                          alt_down,
  output logic                          caps_on,
  output logic                          num_on,
  output logic                          out_free
);
  import ksa_pkg::*;

  ksa_result_t held;

  assign out_free = ~char_valid | ~char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (out_free) begin
      char_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign char_code = held.char_code;
  assign alt_down  = held.alt_down;
  assign caps_on   = held.caps_on;
  assign num_on    = held.num_on;

endmodule
